[rtl/core/phpgc_pkg.sv]
package phpgc_pkg;

    // Default widths for the top-level parameters.
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_COUNT_BITS  = 16;

    // Fixed widths of the configuration registers and the level sum.
    localparam int GATE_BITS = 17;
    localparam int FALL_BITS = 4;
    localparam int RISE_BITS = 5;
    localparam int SUM_BITS  = 28;
    localparam int CFG_INDEX_BITS = 2;

    // Thresholds are expressed in tenths.
    localparam int TENTHS_SCALE = 10;

    // Register reset values.
    localparam logic [GATE_BITS-1:0] GATE_TICKS_RESET  = GATE_BITS'(40000);
    localparam logic [FALL_BITS-1:0] FALL_TENTHS_RESET = FALL_BITS'(9);
    localparam logic [RISE_BITS-1:0] RISE_TENTHS_RESET = RISE_BITS'(11);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GATE_TICKS  = 2'd0,
        REG_FALL_TENTHS = 2'd1,
        REG_RISE_TENTHS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [FALL_BITS-1:0] fall;
        logic [RISE_BITS-1:0] rise;
    } thresh_t;

endpackage

[rtl/core/phpgc_tracker.sv]
module phpgc_tracker #(
    parameter int SAMPLE_BITS = phpgc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  phpgc_pkg::thresh_t     thresh,
    output logic                   pulse
);

    localparam int PW = SAMPLE_BITS + 5;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [PW-1:0] TEN = PW'(phpgc_pkg::TENTHS_SCALE);

    logic                   high_reg;
    logic                   high_next;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [SAMPLE_BITS-1:0] valley_reg;
    logic [SAMPLE_BITS-1:0] valley_next;

    logic [SAMPLE_BITS-1:0] peak_max;
    logic [SAMPLE_BITS-1:0] valley_min;
    logic [PW-1:0]          scaled;
    logic [PW-1:0]          fall_lim;
    logic [PW-1:0]          rise_lim;
    logic                   rearm;

    always_comb
    begin
        peak_max   = (sample > peak_reg) ? sample : peak_reg;
        valley_min = (sample < valley_reg) ? sample : valley_reg;
        scaled     = PW'(sample) * TEN;
        fall_lim   = PW'(peak_max) * PW'(thresh.fall);
        rise_lim   = PW'(valley_min) * PW'(thresh.rise);
        pulse      = high_reg && (scaled < fall_lim);
        rearm      = !high_reg && (scaled > rise_lim);
    end

    always_comb
    begin
        high_next   = high_reg;
        peak_next   = peak_reg;
        valley_next = valley_reg;
        if (step)
        begin
            if (high_reg)
            begin
                // A pulse drops the peak so the next high phase starts afresh.
                peak_next = pulse ? '0 : peak_max;
                high_next = !pulse;
            end
            else
            begin
                valley_next = rearm ? SAMPLE_MAX : valley_min;
                high_next   = rearm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg   <= 1'b1;
            peak_reg   <= '0;
            valley_reg <= SAMPLE_MAX;
        end
        else
        begin
            high_reg   <= high_next;
            peak_reg   <= peak_next;
            valley_reg <= valley_next;
        end
    end

    a_low_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !high_reg |-> peak_reg == '0)
        else $error("peak not cleared during low phase");

    a_high_valley_max: assert property (@(posedge clk) disable iff (!rst_n)
        high_reg |-> valley_reg == SAMPLE_MAX)
        else $error("valley not at full scale during high phase");

    a_pulse_to_low: assert property (@(posedge clk) disable iff (!rst_n)
        step && pulse |=> !high_reg)
        else $error("pulse did not enter low phase");

endmodule

[rtl/core/peak_hysteresis_pulse_gate_counter.sv]
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     sample
// out      output     out_valid / out_stall   pulse_count, first_edge_ticks,
//                                             last_edge_ticks, level_sum
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is taken every cycle while in_stall is low; a word passes an
// input register, then a single update stage that writes the window state
// and, on a window close, the result register. Reset clears all state but
// the sample and result data registers; no clearing pass is needed. A word
// that closes a window waits in the input register while the result register
// is full and stalled; other words go on regardless of out_stall.
module peak_hysteresis_pulse_gate_counter #(
    parameter int SAMPLE_BITS = phpgc_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = phpgc_pkg::DEF_COUNT_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [SAMPLE_BITS-1:0]               sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [COUNT_BITS-1:0]                pulse_count,
    output logic [COUNT_BITS:0]                  first_edge_ticks,
    output logic [COUNT_BITS:0]                  last_edge_ticks,
    output logic [phpgc_pkg::SUM_BITS-1:0]       level_sum,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [phpgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [phpgc_pkg::GATE_BITS-1:0]      cfg_data
);

    localparam int SB = phpgc_pkg::SUM_BITS;
    localparam int GB = phpgc_pkg::GATE_BITS;
    localparam int LW = (COUNT_BITS + 1 > GB) ? COUNT_BITS + 1 : GB;
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS:0]   EDGE_MAX = '1;
    localparam logic [SB-1:0]         SUM_MAX  = '1;

    // Configuration registers.
    logic [GB-1:0]      gate_ticks_reg;
    phpgc_pkg::thresh_t thresh_reg;

    // Input register.
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    // Window state.
    logic [COUNT_BITS-1:0] gate_count_reg;
    logic [COUNT_BITS-1:0] gate_count_next;
    logic [COUNT_BITS-1:0] pulses_reg;
    logic [COUNT_BITS-1:0] pulses_next;
    logic [COUNT_BITS:0]   first_reg;
    logic [COUNT_BITS:0]   first_next;
    logic [COUNT_BITS:0]   last_reg;
    logic [COUNT_BITS:0]   last_next;
    logic                  bfe_reg;
    logic                  bfe_next;
    logic                  summing_reg;
    logic                  summing_next;
    logic [SB-1:0]         partial_reg;
    logic [SB-1:0]         partial_next;
    logic [SB-1:0]         window_reg;
    logic [SB-1:0]         window_next;

    // Result register.
    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] res_pulses_reg;
    logic [COUNT_BITS:0]   res_first_reg;
    logic [COUNT_BITS:0]   res_last_reg;
    logic [SB-1:0]         res_sum_reg;

    logic [GB-1:0] gate_last;
    logic [LW-1:0] gate_lim;
    logic          close;
    logic          out_free;
    logic          advance;
    logic          pulse;
    logic          in_take;
    logic [SB:0]   window_add;
    logic [SB:0]   partial_add;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_ticks_reg  <= phpgc_pkg::GATE_TICKS_RESET;
            thresh_reg.fall <= phpgc_pkg::FALL_TENTHS_RESET;
            thresh_reg.rise <= phpgc_pkg::RISE_TENTHS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                phpgc_pkg::REG_GATE_TICKS:  gate_ticks_reg  <= cfg_data;
                phpgc_pkg::REG_FALL_TENTHS: thresh_reg.fall <= cfg_data[phpgc_pkg::FALL_BITS-1:0];
                phpgc_pkg::REG_RISE_TENTHS: thresh_reg.rise <= cfg_data[phpgc_pkg::RISE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A gate length of zero behaves as one; one beyond the counter range is
    // clipped to the full counter range.
    always_comb
    begin
        gate_last = (gate_ticks_reg == '0) ? '0 : gate_ticks_reg - GB'(1);
        gate_lim  = (LW'(gate_last) > LW'(CNT_MAX)) ? LW'(CNT_MAX) : LW'(gate_last);
        close     = (LW'(gate_count_reg) == gate_lim);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!close || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_take || (s1_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
        end
    end

    phpgc_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (s1_sample_reg),
        .thresh (thresh_reg),
        .pulse  (pulse)
    );

    always_comb
    begin
        gate_count_next = gate_count_reg;
        pulses_next     = pulses_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        bfe_next        = bfe_reg;
        summing_next    = summing_reg;
        partial_next    = partial_reg;
        window_next     = window_reg;
        window_add      = '0;
        partial_add     = '0;
        if (advance)
        begin
            // The window close clears the running counts before this word's
            // pulse tracking and counting are applied.
            if (close)
            begin
                gate_count_next = '0;
                pulses_next     = '0;
                first_next      = '0;
                last_next       = '0;
                bfe_next        = 1'b1;
                summing_next    = 1'b0;
                partial_next    = '0;
                window_next     = '0;
            end
            else
            begin
                gate_count_next = gate_count_reg + COUNT_BITS'(1);
            end

            if (pulse)
            begin
                pulses_next  = (pulses_next == CNT_MAX) ? CNT_MAX
                                                        : pulses_next + COUNT_BITS'(1);
                last_next    = '0;
                bfe_next     = 1'b0;
                summing_next = 1'b1;
                window_add   = {1'b0, window_next} + {1'b0, partial_next};
                window_next  = window_add[SB] ? SUM_MAX : window_add[SB-1:0];
                partial_next = '0;
            end

            last_next = (last_next == EDGE_MAX) ? EDGE_MAX : last_next + (COUNT_BITS+1)'(1);
            if (bfe_next)
            begin
                first_next = (first_next == EDGE_MAX) ? EDGE_MAX
                                                      : first_next + (COUNT_BITS+1)'(1);
            end
            if (summing_next)
            begin
                partial_add  = {1'b0, partial_next} + (SB+1)'(s1_sample_reg);
                partial_next = (partial_add > (SB+1)'(SUM_MAX)) ? SUM_MAX
                                                                : partial_add[SB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_count_reg <= '0;
            pulses_reg     <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            bfe_reg        <= 1'b1;
            summing_reg    <= 1'b0;
            partial_reg    <= '0;
            window_reg     <= '0;
        end
        else
        begin
            gate_count_reg <= gate_count_next;
            pulses_reg     <= pulses_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            bfe_reg        <= bfe_next;
            summing_reg    <= summing_next;
            partial_reg    <= partial_next;
            window_reg     <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && close)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && close)
        begin
            res_pulses_reg <= pulses_reg;
            res_first_reg  <= first_reg;
            res_last_reg   <= last_reg;
            res_sum_reg    <= window_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pulse_count      = res_pulses_reg;
    assign first_edge_ticks = res_first_reg;
    assign last_edge_ticks  = res_last_reg;
    assign level_sum        = res_sum_reg;

    a_close_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && close |=> out_valid_reg && gate_count_reg == '0)
        else $error("window close did not produce a result word");

    a_edges_track: assert property (@(posedge clk) disable iff (!rst_n)
        bfe_reg |-> first_reg == last_reg)
        else $error("edge counters diverged before the first pulse");

    a_idle_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !summing_reg |-> partial_reg == '0)
        else $error("partial sum held while not summing");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(advance && close))
        else $error("result word overwritten while stalled");

endmodule
